// ----- design/assert_macros.svh -----
// Assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, quiet while reset is high
`define TUN_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked check that also covers the reset cycles
`define TUN_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- design/tun_pkg.sv -----
// Shared constants and width helpers for the triangle unit normal block
package tun_pkg;

  localparam int NORM_BITS = 30;
  localparam int ROOT_W    = NORM_BITS + 1;
  localparam int SUM_W     = 2 * NORM_BITS + 2;
  localparam int CHUNK_W   = 8;
  localparam int QUEUE_DEPTH = 4;

  // width of a cross product component magnitude
  function automatic int mag_w(input int coord_w);
    return 2 * coord_w + 2;
  endfunction

  // width of one queue item: three magnitudes, three signs, degenerate flag
  function automatic int item_w(input int coord_w);
    return 3 * mag_w(coord_w) + 4;
  endfunction

endpackage

// ----- design/triangle_unit_normal_top.sv -----
// Top level of the triangle unit normal block
//
// Input channel (in_valid / in_ready): one triangle per item, corners a, b, c
// as signed COORD_WIDTH-bit coordinates. Output channel (out_valid /
// out_ready): one item per triangle with the unit normal nx, ny, nz as
// signed values with NORMAL_FRAC_BITS fraction bits, and degenerate, which is
// set with all components zero when the cross product is zero.
// Results leave in input order.
// The path runs through three front stages, one queue entry, five shift and
// square stages, a sum stage, 31 square root stages, NORMAL_FRAC_BITS + 2
// divide stages and the output register.
// Throughput is one item per cycle while nothing stalls; front and back
// pipelines step once per cycle unless held; three divides run side by side.
// Reset clears every valid flag and the queue; no item is in flight after it.
// The back pipeline holds while out_valid is high and out_ready is low; the
// front accepts until the four-entry queue is full and an item waits to push.
module triangle_unit_normal_top #(
  parameter int COORD_WIDTH      = 16,
  parameter int NORMAL_FRAC_BITS = 14
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [COORD_WIDTH-1:0]     ax,
  input  logic signed [COORD_WIDTH-1:0]     ay,
  input  logic signed [COORD_WIDTH-1:0]     az,
  input  logic signed [COORD_WIDTH-1:0]     bx,
  input  logic signed [COORD_WIDTH-1:0]     by_coord,
  input  logic signed [COORD_WIDTH-1:0]     bz,
  input  logic signed [COORD_WIDTH-1:0]     cx,
  input  logic signed [COORD_WIDTH-1:0]     cy,
  input  logic signed [COORD_WIDTH-1:0]     cz,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [NORMAL_FRAC_BITS+1:0] nx,
  output logic signed [NORMAL_FRAC_BITS+1:0] ny,
  output logic signed [NORMAL_FRAC_BITS+1:0] nz,
  output logic                              degenerate
);
  import tun_pkg::*;

  localparam int IW = item_w(COORD_WIDTH);

  logic          q_push;
  logic          q_full;
  logic          q_pop;
  logic          q_empty;
  logic [IW-1:0] q_in;
  logic [IW-1:0] q_out;

  tun_front #(.CW(COORD_WIDTH)) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .ax       (ax),
    .ay       (ay),
    .az       (az),
    .bx       (bx),
    .by_coord (by_coord),
    .bz       (bz),
    .cx       (cx),
    .cy       (cy),
    .cz       (cz),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_in)
  );

  tun_fifo #(.W(IW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .empty     (q_empty)
  );

  tun_back #(.CW(COORD_WIDTH), .F(NORMAL_FRAC_BITS)) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .q_data     (q_out),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .nx         (nx),
    .ny         (ny),
    .nz         (nz),
    .degenerate (degenerate)
  );

endmodule

// ----- design/tun_fifo.sv -----
// Small register queue between the front and back parts
module tun_fifo #(
  parameter int W     = 16,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] pop_data,
  output logic         empty
);
  import tun_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [W-1:0]  mem [DEPTH];
  logic [AW-1:0] wp;
  logic [AW-1:0] rp;
  logic [AW:0]   cnt;

  assign full     = (cnt == (AW+1)'(DEPTH));
  assign empty    = (cnt == '0);
  assign pop_data = mem[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) begin
        wp <= (wp == AW'(DEPTH - 1)) ? '0 : wp + 1'b1;
      end
      if (pop) begin
        rp <= (rp == AW'(DEPTH - 1)) ? '0 : rp + 1'b1;
      end
      case ({push, pop})
        2'b10:   cnt <= cnt + 1'b1;
        2'b01:   cnt <= cnt - 1'b1;
        default: cnt <= cnt;
      endcase
    end
  end

endmodule

// ----- design/tun_front.sv -----
// Front part: accepts triangles, forms edges and cross product, classifies
module tun_front #(
  parameter int CW = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [CW-1:0]               ax,
  input  logic signed [CW-1:0]               ay,
  input  logic signed [CW-1:0]               az,
  input  logic signed [CW-1:0]               bx,
  input  logic signed [CW-1:0]               by_coord,
  input  logic signed [CW-1:0]               bz,
  input  logic signed [CW-1:0]               cx,
  input  logic signed [CW-1:0]               cy,
  input  logic signed [CW-1:0]               cz,
  input  logic                               q_full,
  output logic                               q_push,
  output logic [tun_pkg::item_w(CW)-1:0]     q_data
);
  import tun_pkg::*;

  localparam int EW = CW + 1;
  localparam int PW = 2 * EW;
  localparam int XW = PW + 1;
  localparam int MW = mag_w(CW);

  logic en;
  logic v1, v2, v3;
  logic signed [EW-1:0] e1x, e1y, e1z, e2x, e2y, e2z;
  logic signed [PW-1:0] p_yz, p_zy, p_zx, p_xz, p_xy, p_yx;
  logic signed [XW-1:0] ci, cj, ck;
  logic [XW-1:0] ni, nj, nk;
  logic [MW-1:0] mi, mj, mk;

  assign en       = !v3 || !q_full;
  assign in_ready = en;
  assign q_push   = v3 && !q_full;

  assign ci = {p_yz[PW-1], p_yz} - {p_zy[PW-1], p_zy};
  assign cj = {p_zx[PW-1], p_zx} - {p_xz[PW-1], p_xz};
  assign ck = {p_xy[PW-1], p_xy} - {p_yx[PW-1], p_yx};
  assign ni = -ci;
  assign nj = -cj;
  assign nk = -ck;
  assign mi = ci[XW-1] ? ni[MW-1:0] : ci[MW-1:0];
  assign mj = cj[XW-1] ? nj[MW-1:0] : cj[MW-1:0];
  assign mk = ck[XW-1] ? nk[MW-1:0] : ck[MW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e1x <= {bx[CW-1], bx} - {ax[CW-1], ax};
      e1y <= {by_coord[CW-1], by_coord} - {ay[CW-1], ay};
      e1z <= {bz[CW-1], bz} - {az[CW-1], az};
      e2x <= {cx[CW-1], cx} - {ax[CW-1], ax};
      e2y <= {cy[CW-1], cy} - {ay[CW-1], ay};
      e2z <= {cz[CW-1], cz} - {az[CW-1], az};
      p_yz <= e1y * e2z;
      p_zy <= e1z * e2y;
      p_zx <= e1z * e2x;
      p_xz <= e1x * e2z;
      p_xy <= e1x * e2y;
      p_yx <= e1y * e2x;
      q_data <= {(mi == '0) && (mj == '0) && (mk == '0),
                 ck[XW-1], cj[XW-1], ci[XW-1], mk, mj, mi};
    end
  end

endmodule

// ----- design/tun_back.sv -----
// Back part: normalising shift, squared length, square root, divides, output register
module tun_back #(
  parameter int CW = 16,
  parameter int F  = 14
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           q_empty,
  input  logic [tun_pkg::item_w(CW)-1:0] q_data,
  output logic                           q_pop,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [F+1:0]            nx,
  output logic signed [F+1:0]            ny,
  output logic signed [F+1:0]            nz,
  output logic                           degenerate
);
  import tun_pkg::*;

  localparam int MW  = mag_w(CW);
  localparam int NB  = NORM_BITS;
  localparam int RW  = ROOT_W;
  localparam int SW  = SUM_W;
  localparam int NCH = (MW + CHUNK_W - 1) / CHUNK_W;
  localparam int BLW = $clog2(MW + 1);
  localparam int CLW = $clog2(CHUNK_W + 1);
  localparam int D   = F + 1;
  localparam int NW  = NB + F + 1;
  localparam int OW  = F + 2;

  logic en;

  // stage 1: queue head
  logic          b1_v;
  logic [MW-1:0] b1_mag [3];
  logic [2:0]    b1_neg;
  logic          b1_deg;
  logic [NCH*CHUNK_W-1:0] b1_or;

  // stage 2: chunk lengths
  logic           b2_v;
  logic [MW-1:0]  b2_mag [3];
  logic [2:0]     b2_neg;
  logic           b2_deg;
  logic [NCH-1:0] b2_nz;
  logic [CLW-1:0] b2_len [NCH];
  logic [CLW-1:0] ch_len [NCH];

  // stage 3: bit length of largest magnitude
  logic           b3_v;
  logic [MW-1:0]  b3_mag [3];
  logic [2:0]     b3_neg;
  logic           b3_deg;
  logic [BLW-1:0] b3_bl;
  logic [BLW-1:0] bl_sel;

  // stage 4: scaled magnitudes
  logic          b4_v;
  logic [NB-1:0] b4_m [3];
  logic [2:0]    b4_neg;
  logic          b4_deg;
  logic [MW+NB-1:0] sh [3];

  // stage 5: squares
  logic            b5_v;
  logic [NB-1:0]   b5_m [3];
  logic [2*NB-1:0] b5_sq [3];
  logic [2:0]      b5_neg;
  logic            b5_deg;

  // root stages
  logic            sr_v    [RW+1];
  logic [SW-1:0]   sr_s    [RW+1];
  logic [RW+1:0]   sr_rem  [RW+1];
  logic [RW-1:0]   sr_root [RW+1];
  logic [NB-1:0]   sr_m    [RW+1][3];
  logic [2:0]      sr_neg  [RW+1];
  logic            sr_deg  [RW+1];
  logic [RW+1:0]   sr_r2   [RW];
  logic [RW+1:0]   sr_tr   [RW];
  logic            sr_ge   [RW];

  // divide stages
  logic            dv_v   [D+1];
  logic [RW-1:0]   dv_l   [D+1];
  logic [RW-1:0]   dv_rem [D+1][3];
  logic [D-1:0]    dv_nl  [D+1][3];
  logic [D-1:0]    dv_q   [D+1][3];
  logic [2:0]      dv_neg [D+1];
  logic            dv_deg [D+1];
  logic [RW:0]     dv_r2  [D][3];
  logic            dv_ge  [D][3];
  logic [NW-1:0]   num    [3];
  logic [OW-1:0]   res    [3];

  assign en    = !out_valid || out_ready;
  assign q_pop = en && !q_empty;

  always_comb begin
    b1_or = '0;
    b1_or[MW-1:0] = b1_mag[0] | b1_mag[1] | b1_mag[2];
    for (int c = 0; c < NCH; c++) begin
      ch_len[c] = '0;
      for (int i = 0; i < CHUNK_W; i++) begin
        if (b1_or[c*CHUNK_W + i]) begin
          ch_len[c] = CLW'(i + 1);
        end
      end
    end
    bl_sel = '0;
    for (int c = 0; c < NCH; c++) begin
      if (b2_nz[c]) begin
        bl_sel = BLW'(c * CHUNK_W) + BLW'(b2_len[c]);
      end
    end
    for (int q = 0; q < 3; q++) begin
      sh[q] = {b3_mag[q], {NB{1'b0}}} >> b3_bl;
    end
    for (int k = 0; k < RW; k++) begin
      sr_r2[k] = {sr_rem[k][RW-1:0], sr_s[k][2*(RW-1-k) +: 2]};
      sr_tr[k] = {sr_root[k], 2'b01};
      sr_ge[k] = (sr_r2[k] >= sr_tr[k]);
    end
    for (int q = 0; q < 3; q++) begin
      num[q] = {1'b0, sr_m[RW][q], {F{1'b0}}} + NW'(sr_root[RW] >> 1);
    end
    for (int k = 0; k < D; k++) begin
      for (int q = 0; q < 3; q++) begin
        dv_r2[k][q] = {dv_rem[k][q], dv_nl[k][q][D-1-k]};
        dv_ge[k][q] = (dv_r2[k][q] >= {1'b0, dv_l[k]});
      end
    end
    for (int q = 0; q < 3; q++) begin
      res[q] = dv_neg[D][q] ? -OW'(dv_q[D][q]) : OW'(dv_q[D][q]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_v <= 1'b0;
      b2_v <= 1'b0;
      b3_v <= 1'b0;
      b4_v <= 1'b0;
      b5_v <= 1'b0;
      for (int k = 0; k <= RW; k++) begin
        sr_v[k] <= 1'b0;
      end
      for (int k = 0; k <= D; k++) begin
        dv_v[k] <= 1'b0;
      end
      out_valid <= 1'b0;
    end else if (en) begin
      b1_v <= !q_empty;
      b2_v <= b1_v;
      b3_v <= b2_v;
      b4_v <= b3_v;
      b5_v <= b4_v;
      sr_v[0] <= b5_v;
      for (int k = 0; k < RW; k++) begin
        sr_v[k+1] <= sr_v[k];
      end
      dv_v[0] <= sr_v[RW];
      for (int k = 0; k < D; k++) begin
        dv_v[k+1] <= dv_v[k];
      end
      out_valid <= dv_v[D];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b1_mag[0] <= q_data[MW-1:0];
      b1_mag[1] <= q_data[2*MW-1:MW];
      b1_mag[2] <= q_data[3*MW-1:2*MW];
      b1_neg    <= q_data[3*MW+2:3*MW];
      b1_deg    <= q_data[3*MW+3];

      b2_mag <= b1_mag;
      b2_neg <= b1_neg;
      b2_deg <= b1_deg;
      for (int c = 0; c < NCH; c++) begin
        b2_nz[c]  <= (b1_or[c*CHUNK_W +: CHUNK_W] != '0);
        b2_len[c] <= ch_len[c];
      end

      b3_mag <= b2_mag;
      b3_neg <= b2_neg;
      b3_deg <= b2_deg;
      b3_bl  <= bl_sel;

      for (int q = 0; q < 3; q++) begin
        b4_m[q] <= sh[q][NB-1:0];
      end
      b4_neg <= b3_neg;
      b4_deg <= b3_deg;

      for (int q = 0; q < 3; q++) begin
        b5_sq[q] <= b4_m[q] * b4_m[q];
      end
      b5_m   <= b4_m;
      b5_neg <= b4_neg;
      b5_deg <= b4_deg;

      sr_s[0]    <= SW'(b5_sq[0]) + SW'(b5_sq[1]) + SW'(b5_sq[2]);
      sr_rem[0]  <= '0;
      sr_root[0] <= '0;
      sr_m[0]    <= b5_m;
      sr_neg[0]  <= b5_neg;
      sr_deg[0]  <= b5_deg;
      for (int k = 0; k < RW; k++) begin
        sr_s[k+1]    <= sr_s[k];
        sr_rem[k+1]  <= sr_ge[k] ? sr_r2[k] - sr_tr[k] : sr_r2[k];
        sr_root[k+1] <= {sr_root[k][RW-2:0], sr_ge[k]};
        sr_m[k+1]    <= sr_m[k];
        sr_neg[k+1]  <= sr_neg[k];
        sr_deg[k+1]  <= sr_deg[k];
      end

      dv_l[0]   <= sr_root[RW];
      dv_neg[0] <= sr_neg[RW];
      dv_deg[0] <= sr_deg[RW];
      for (int q = 0; q < 3; q++) begin
        dv_rem[0][q] <= RW'(num[q][NW-1:D]);
        dv_nl[0][q]  <= num[q][D-1:0];
        dv_q[0][q]   <= '0;
      end
      for (int k = 0; k < D; k++) begin
        dv_l[k+1]   <= dv_l[k];
        dv_neg[k+1] <= dv_neg[k];
        dv_deg[k+1] <= dv_deg[k];
        for (int q = 0; q < 3; q++) begin
          dv_rem[k+1][q] <= dv_ge[k][q] ? RW'(dv_r2[k][q] - {1'b0, dv_l[k]})
                                        : RW'(dv_r2[k][q]);
          dv_nl[k+1][q]  <= dv_nl[k][q];
          dv_q[k+1][q]   <= {dv_q[k][q][D-2:0], dv_ge[k][q]};
        end
      end

      nx         <= dv_deg[D] ? '0 : res[0];
      ny         <= dv_deg[D] ? '0 : res[1];
      nz         <= dv_deg[D] ? '0 : res[2];
      degenerate <= dv_deg[D];
    end
  end

endmodule

// ----- design/tun_checker.sv -----
// Port checker for the triangle unit normal block, bound to the top level
`include "assert_macros.svh"

module tun_checker #(
  parameter int OUT_W = 16
) (
  input logic                    clk,
  input logic                    rst,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic signed [OUT_W-1:0] nx,
  input logic signed [OUT_W-1:0] ny,
  input logic signed [OUT_W-1:0] nz,
  input logic                    degenerate
);

  `TUN_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(nx) && $stable(ny) && $stable(nz) && $stable(degenerate), "tun: stalled item changed")
  `TUN_ASSERT(a_degen_zero, out_valid && degenerate |-> nx == 0 && ny == 0 && nz == 0, "tun: degenerate item with non-zero normal")
  `TUN_ASSERT(a_normal_nonzero, out_valid && !degenerate |-> !(nx == 0 && ny == 0 && nz == 0), "tun: zero normal without degenerate")
  `TUN_ASSERT_RST(a_reset_idle, rst |=> !out_valid, "tun: item out straight after reset")

endmodule

bind triangle_unit_normal_top tun_checker #(.OUT_W(NORMAL_FRAC_BITS + 2)) u_tun_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .nx         (nx),
  .ny         (ny),
  .nz         (nz),
  .degenerate (degenerate)
);

// ----- dv/tb.sv -----
// Testbench for the triangle unit normal block: random and corner triangles
`timescale 1ns / 100ps

class normal_scoreboard;
  typedef struct {
    logic signed [15:0] x, y, z;
    logic               degen;
  } normal_t;

  normal_t pending[$];
  int      errors;
  int      checked;
  int      degen_seen;

  function automatic void predict_normal(
    input logic signed [15:0] ax, ay, az, bx, by, bz, cx, cy, cz);
    logic signed [127:0] e1x, e1y, e1z, e2x, e2y, e2z;
    logic signed [127:0] comp [3];
    logic [127:0]        mag [3];
    logic [63:0]         m [3];
    logic [63:0]         sum, rem, root, bitv, q;
    bit                  neg [3];
    int                  blen;
    normal_t             r;
    e1x = bx - ax; e1y = by - ay; e1z = bz - az;
    e2x = cx - ax; e2y = cy - ay; e2z = cz - az;
    comp[0] = e1y * e2z - e1z * e2y;
    comp[1] = e1z * e2x - e1x * e2z;
    comp[2] = e1x * e2y - e1y * e2x;
    blen = 0;
    for (int i = 0; i < 3; i++) begin
      neg[i] = comp[i] < 0;
      mag[i] = neg[i] ? -comp[i] : comp[i];
      for (int b = 0; b < 128; b++) if (mag[i][b] && b + 1 > blen) blen = b + 1;
    end
    if (blen == 0) begin
      r.x = 0; r.y = 0; r.z = 0; r.degen = 1'b1;
      pending.push_back(r);
      return;
    end
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      if (blen <= 30) m[i] = 64'(mag[i] << (30 - blen));
      else m[i] = 64'(mag[i] >> (blen - 30));
      sum += m[i] * m[i];
    end
    rem = sum; root = 0; bitv = 64'd1 << 62;
    while (bitv > rem) bitv >>= 2;
    while (bitv != 0) begin
      if (rem >= root + bitv) begin
        rem -= root + bitv; root = (root >> 1) + bitv;
      end else root >>= 1;
      bitv >>= 2;
    end
    for (int i = 0; i < 3; i++) begin
      q = ((m[i] << 14) + (root >> 1)) / root;
      if (neg[i]) q = -q;
      if (i == 0) r.x = q[15:0];
      else if (i == 1) r.y = q[15:0];
      else r.z = q[15:0];
    end
    r.degen = 1'b0;
    pending.push_back(r);
  endfunction

  function automatic void check_normal(input logic signed [15:0] x, y, z,
                                       input logic degen);
    normal_t e;
    if (pending.size() == 0) begin
      $error("result with nothing expected");
      errors++;
      return;
    end
    e = pending.pop_front();
    checked++;
    if (degen) degen_seen++;
    if (x !== e.x) begin $error("nx exp %0d got %0d", e.x, x); errors++; end
    if (y !== e.y) begin $error("ny exp %0d got %0d", e.y, y); errors++; end
    if (z !== e.z) begin $error("nz exp %0d got %0d", e.z, z); errors++; end
    if (degen !== e.degen) begin
      $error("degenerate exp %0b got %0b", e.degen, degen); errors++;
    end
  endfunction
endclass

module tb;
  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0, out_ready = 0;
  logic in_ready, out_valid, degenerate;
  logic signed [15:0] ax = 0, ay = 0, az = 0, bx = 0, by_coord = 0, bz = 0;
  logic signed [15:0] cx = 0, cy = 0, cz = 0;
  logic signed [15:0] nx, ny, nz;
  int send_idle = 0, recv_stall = 0;
  int cycles = 0;
  int sent = 0;
  normal_scoreboard sb = new();

  triangle_unit_normal_top dut (.*);

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_normal(nx, ny, nz, degenerate);
    out_ready <= ($urandom_range(99) >= recv_stall);
  end

  always @(posedge clk)
    if (!rst && in_valid && in_ready)
      sb.predict_normal(ax, ay, az, bx, by_coord, bz, cx, cy, cz);

  function automatic logic [15:0] pick_coord();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($urandom_range(8)) - 16'd4;
      3: return 16'($urandom_range(200)) - 16'd100;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_triangle(input logic [15:0] v [9]);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    {ax, ay, az} <= {v[0], v[1], v[2]};
    {bx, by_coord, bz} <= {v[3], v[4], v[5]};
    {cx, cy, cz} <= {v[6], v[7], v[8]};
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  task automatic send_random(input int count);
    logic [15:0] v [9];
    for (int n = 0; n < count; n++) begin
      for (int i = 0; i < 9; i++) v[i] = pick_coord();
      case ($urandom_range(9))
        0: for (int i = 3; i < 9; i++) v[i] = v[i % 3];  // coincident corners
        1: for (int i = 0; i < 3; i++) v[6 + i] = 16'(2 * v[3 + i] - v[i]); // collinear when 2b - a fits
        default: ;
      endcase
      send_triangle(v);
    end
  endtask

  initial begin
    logic [15:0] v [9];
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    // corners at the coordinate extremes and zero
    for (int k = 0; k < 16; k++) begin
      for (int i = 0; i < 9; i++) v[i] = ((k + i) % 3 == 0) ? 16'h8000 :
                                        ((k + i) % 3 == 1) ? 16'h7fff : 16'h0000;
      send_triangle(v);
    end
    v = '{default: 16'h0000}; send_triangle(v);                // all coincident
    v = '{16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h7fff,
          16'h0000, 16'h0000, 16'h0000}; send_triangle(v);     // collinear
    v = '{0, 0, 0, 1, 0, 0, 0, 1, 0}; send_triangle(v);        // axis aligned
    v = '{0, 0, 0, 0, 1, 0, 1, 0, 0}; send_triangle(v);
    v = '{0, 0, 0, 0, 0, 1, 1, 0, 0}; send_triangle(v);
    v = '{0, 0, 0, 1, 1, 0, 0, 1, 1}; send_triangle(v);
    send_idle = 0;  recv_stall = 0;  send_random(350);
    send_idle = 59; recv_stall = 0;  send_random(330);
    send_idle = 0;  recv_stall = 59; send_random(330);
    send_idle = 21; recv_stall = 21; send_random(330);
    in_valid <= 1'b0;
    recv_stall = 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (sb.pending.size() != 0) begin
      $error("%0d normals never came out", sb.pending.size());
      sb.errors++;
    end
    $display("%0d triangles sent, %0d normals checked, %0d degenerate",
             sent, sb.checked, sb.degen_seen);
    if (sb.errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end
endmodule

// ----- sim.f -----
+incdir+design
design/tun_pkg.sv
design/tun_fifo.sv
design/tun_front.sv
design/tun_back.sv
design/triangle_unit_normal_top.sv
design/tun_checker.sv
dv/tb.sv
